[src/kdrl_pkg.sv]
// Shared types and constants for the key debouncer with auto repeat and long press.
package kdrl_pkg;

    localparam int DEBOUNCE_W = 16;
    localparam int DELAY_W    = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd5000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERT_LEVEL   = 3'd0,
        CFG_DEBOUNCE_TICKS = 3'd1,
        CFG_REPEAT_PERIOD  = 3'd2,
        CFG_REPEAT_DELAY   = 3'd3,
        CFG_LONG_PRESS     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic press_event;
        logic repeat_flag;
        logic release_event;
        logic long_press_event;
        logic key_pressed;
    } result_t;

endpackage

[src/key_debounce_repeat_longpress.sv]
// Key debouncer with auto repeat and long press: top level.
// Each input word is one time tick carrying the raw key level; every accepted
// tick yields exactly one result word, registered in the output slot or the skid slot.
// The block takes one tick per clock while in_stall is low: the debounce, repeat and long-press
// counters are updated by a single decrement-and-compare pass per tick, and a
// one-word skid stage lets a tick be accepted while the previous result still
// waits on out_stall. in_stall rises only when both result slots are full.
// Configuration writes are always accepted (cfg_ready is tied high) and should
// be issued only while no tick is in flight.
module key_debounce_repeat_longpress #(
    parameter int TIME_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kdrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdrl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            raw_level,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            press_event,
    output logic                            repeat_flag,
    output logic                            release_event,
    output logic                            long_press_event,
    output logic                            key_pressed
);
    import kdrl_pkg::*;

    localparam int EXT_W = (TIME_BITS > DELAY_W) ? TIME_BITS : DELAY_W;
    localparam logic [EXT_W-1:0] TIME_MAX_EXT = EXT_W'({TIME_BITS{1'b1}});

    // delay of d ticks (d >= 1) as a counter load, saturated to TIME_BITS
    function automatic logic [TIME_BITS-1:0] load_delay(input logic [DELAY_W-1:0] d);
        logic [EXT_W-1:0] v;
        v = EXT_W'(d - DELAY_W'(1));
        if (v > TIME_MAX_EXT)
            return {TIME_BITS{1'b1}};
        else
            return v[TIME_BITS-1:0];
    endfunction

    logic                  invert_level_reg;
    logic [DEBOUNCE_W-1:0] debounce_ticks_reg;
    logic [DELAY_W-1:0]    repeat_period_reg;
    logic [DELAY_W-1:0]    repeat_delay_reg;
    logic [DELAY_W-1:0]    long_press_reg;

    logic                  last_level_reg, last_level_next;
    logic                  stable_reg, stable_next;
    logic                  db_active_reg, db_active_next;
    logic [DEBOUNCE_W-1:0] db_count_reg, db_count_next;
    logic                  rep_active_reg, rep_active_next;
    logic [TIME_BITS-1:0]  rep_count_reg, rep_count_next;
    logic                  long_active_reg, long_active_next;
    logic [TIME_BITS-1:0]  long_count_reg, long_count_next;

    logic    out_valid_reg, skid_valid_reg;
    result_t out_word_reg, skid_word_reg;
    result_t res;

    logic level, armed, accept, drain;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !skid_valid_reg;
    assign drain     = out_valid_reg && !out_stall;

    always_comb
    begin
        level            = raw_level ^ invert_level_reg;
        last_level_next  = last_level_reg;
        stable_next      = stable_reg;
        db_active_next   = db_active_reg;
        db_count_next    = db_count_reg;
        rep_active_next  = rep_active_reg;
        rep_count_next   = rep_count_reg;
        long_active_next = long_active_reg;
        long_count_next  = long_count_reg;
        armed            = 1'b0;
        res              = '0;

        if (level != last_level_reg)
        begin
            last_level_next = level;
            db_active_next  = 1'b1;
            db_count_next   = debounce_ticks_reg;
            rep_active_next = 1'b0;
        end

        if (db_active_next)
        begin
            if (db_count_next == '0)
            begin
                db_active_next = 1'b0;
                if (level != stable_reg)
                begin
                    stable_next = level;
                    if (level)
                    begin
                        res.press_event = 1'b1;
                        armed           = 1'b1;
                        if (repeat_period_reg != '0)
                        begin
                            rep_active_next = 1'b1;
                            rep_count_next  = load_delay((repeat_delay_reg != '0) ?
                                                         repeat_delay_reg : repeat_period_reg);
                        end
                        if (long_press_reg != '0)
                        begin
                            long_active_next = 1'b1;
                            long_count_next  = load_delay(long_press_reg);
                        end
                    end
                    else
                    begin
                        res.release_event = 1'b1;
                        long_active_next  = 1'b0;
                    end
                end
            end
            else
            begin
                db_count_next = db_count_next - DEBOUNCE_W'(1);
            end
        end

        if (!armed)
        begin
            if (rep_active_next)
            begin
                if (rep_count_next == '0)
                begin
                    if (stable_next)
                    begin
                        res.press_event = 1'b1;
                        res.repeat_flag = 1'b1;
                    end
                    rep_count_next = load_delay((repeat_period_reg != '0) ?
                                                repeat_period_reg : DELAY_W'(1));
                end
                else
                begin
                    rep_count_next = rep_count_next - TIME_BITS'(1);
                end
            end
            if (long_active_next)
            begin
                if (long_count_next == '0)
                begin
                    res.long_press_event = stable_next;
                    long_active_next     = 1'b0;
                end
                else
                begin
                    long_count_next = long_count_next - TIME_BITS'(1);
                end
            end
        end

        res.key_pressed = stable_next;
    end

    // config, tick state and result slot control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_level_reg   <= 1'b0;
            debounce_ticks_reg <= DEBOUNCE_RESET;
            repeat_period_reg  <= '0;
            repeat_delay_reg   <= '0;
            long_press_reg     <= '0;
            last_level_reg     <= 1'b0;
            stable_reg         <= 1'b0;
            db_active_reg      <= 1'b0;
            db_count_reg       <= '0;
            rep_active_reg     <= 1'b0;
            rep_count_reg      <= '0;
            long_active_reg    <= 1'b0;
            long_count_reg     <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_INVERT_LEVEL:   invert_level_reg   <= cfg_data[0];
                    CFG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_data[DEBOUNCE_W-1:0];
                    CFG_REPEAT_PERIOD:  repeat_period_reg  <= cfg_data[DELAY_W-1:0];
                    CFG_REPEAT_DELAY:   repeat_delay_reg   <= cfg_data[DELAY_W-1:0];
                    CFG_LONG_PRESS:     long_press_reg     <= cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                last_level_reg  <= last_level_next;
                stable_reg      <= stable_next;
                db_active_reg   <= db_active_next;
                db_count_reg    <= db_count_next;
                rep_active_reg  <= rep_active_next;
                rep_count_reg   <= rep_count_next;
                long_active_reg <= long_active_next;
                long_count_reg  <= long_count_next;
            end

            if (!out_valid_reg || drain)
            begin
                out_valid_reg  <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result words
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || drain)
        begin
            if (skid_valid_reg)
                out_word_reg <= skid_word_reg;
            else if (accept)
                out_word_reg <= res;
        end
        else if (accept)
        begin
            skid_word_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign press_event      = out_word_reg.press_event;
    assign repeat_flag      = out_word_reg.repeat_flag;
    assign release_event    = out_word_reg.release_event;
    assign long_press_event = out_word_reg.long_press_event;
    assign key_pressed      = out_word_reg.key_pressed;

endmodule

[src/kdrl_checker.sv]
// Port-level checks for the key debouncer, bound to the top level.
module kdrl_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic press_event,
    input logic repeat_flag,
    input logic release_event,
    input logic long_press_event,
    input logic key_pressed
);

    // a held result word keeps its press, release and key-pressed bits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(press_event) &&
            $stable(release_event) && $stable(key_pressed))
        else $error("stalled result word changed");

    a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && repeat_flag |-> press_event && key_pressed)
        else $error("repeat flag without a press while held");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_event |-> !key_pressed && !press_event && !long_press_event)
        else $error("release word inconsistent with key state");

    a_press: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (press_event || long_press_event) |-> key_pressed)
        else $error("press or long press while key released");

endmodule

bind key_debounce_repeat_longpress kdrl_checker u_kdrl_checker (.*);

[verif/tb_key_debounce_repeat_longpress.sv]
// Testbench for the key debouncer: directed tick plan, then random key gestures per phase.
module tb_key_debounce_repeat_longpress;
    import kdrl_pkg::*;

    localparam int QUIET_LIMIT = 5000;

    localparam result_t R_IDLE     = 5'b00000;
    localparam result_t R_HELD     = 5'b00001;
    localparam result_t R_PRESS    = 5'b10001;
    localparam result_t R_REPEAT   = 5'b11001;
    localparam result_t R_REP_LONG = 5'b11011;
    localparam result_t R_RELEASE  = 5'b00100;

    typedef struct packed {
        logic                  is_write;
        cfg_idx_t              reg_idx;
        logic [DELAY_W-1:0]    data;
        logic                  level;
        logic                  pinned;
        result_t               want;
    } plan_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  raw_level = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  press_event;
    logic                  repeat_flag;
    logic                  release_event;
    logic                  long_press_event;
    logic                  key_pressed;

    // register copies
    bit                    inv_level = 1'b0;
    bit [DEBOUNCE_W-1:0]   debounce_cfg = DEBOUNCE_RESET;
    bit [DELAY_W-1:0]      period_cfg = '0;
    bit [DELAY_W-1:0]      delay_cfg = '0;
    bit [DELAY_W-1:0]      long_cfg = '0;

    // key state
    bit                    level_seen = 1'b0;
    bit                    held = 1'b0;
    bit                    bounce_busy = 1'b0;
    bit [DEBOUNCE_W-1:0]   bounce_left = '0;
    bit                    rep_on = 1'b0;
    bit [DELAY_W-1:0]      rep_left = '0;
    bit                    long_on = 1'b0;
    bit [DELAY_W-1:0]      long_left = '0;

    result_t               key_result_q[$];
    logic                  pinned_valid = 1'b0;
    result_t               pinned_result = R_IDLE;
    int                    errors = 0;
    int                    quiet_cycles = 0;
    int                    stall_pct = 0;
    int                    send_idle_pct = 0;
    plan_row_t             plan [0:39];

    key_debounce_repeat_longpress i_dut (.*);

    initial forever #5 clk = ~clk;

    function automatic result_t next_key_result(bit raw);
        bit      lvl;
        bit      armed;
        result_t r;
        lvl = raw ^ inv_level;
        r = R_IDLE;
        armed = 1'b0;
        if (lvl != level_seen) begin
            level_seen = lvl;
            bounce_busy = 1'b1;
            bounce_left = debounce_cfg;
            rep_on = 1'b0;
        end
        if (bounce_busy) begin
            if (bounce_left == 0) begin
                bounce_busy = 1'b0;
                if (lvl != held) begin
                    held = lvl;
                    if (lvl) begin
                        r.press_event = 1'b1;
                        armed = 1'b1;
                        if (period_cfg != 0) begin
                            rep_on = 1'b1;
                            rep_left = ((delay_cfg != 0) ? delay_cfg : period_cfg) - 1'b1;
                        end
                        if (long_cfg != 0) begin
                            long_on = 1'b1;
                            long_left = long_cfg - 1'b1;
                        end
                    end
                    else begin
                        r.release_event = 1'b1;
                        long_on = 1'b0;
                    end
                end
            end
            else begin
                bounce_left = bounce_left - 1'b1;
            end
        end
        if (!armed) begin
            if (rep_on) begin
                if (rep_left == 0) begin
                    if (held) begin
                        r.press_event = 1'b1;
                        r.repeat_flag = 1'b1;
                    end
                    rep_left = (period_cfg != 0) ? period_cfg - 1'b1 : '0;
                end
                else begin
                    rep_left = rep_left - 1'b1;
                end
            end
            if (long_on) begin
                if (long_left == 0) begin
                    r.long_press_event = held;
                    long_on = 1'b0;
                end
                else begin
                    long_left = long_left - 1'b1;
                end
            end
        end
        r.key_pressed = held;
        return r;
    endfunction

    function automatic plan_row_t row_write(cfg_idx_t idx, logic [DELAY_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx = idx;
        row.data = val;
        return row;
    endfunction

    function automatic plan_row_t row_tick(logic lvl);
        plan_row_t row;
        row = '0;
        row.reg_idx = CFG_INVERT_LEVEL;
        row.level = lvl;
        return row;
    endfunction

    function automatic plan_row_t row_tick_pin(logic lvl, result_t want);
        plan_row_t row;
        row = row_tick(lvl);
        row.pinned = 1'b1;
        row.want = want;
        return row;
    endfunction

    // zero, any value of the full width, or a short delay
    function automatic logic [DELAY_W-1:0] pick_span(int unsigned top);
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return DELAY_W'($urandom_range(0, 24'hFFFFFF));
        else
            return DELAY_W'($urandom_range(1, top));
    endfunction

    task automatic check_bit(string name, logic want, logic got);
        if (got !== want) begin
            $display("%0t: %s expected %0b got %0b", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic send_tick(logic lvl, logic pin, result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_level <= lvl;
        pinned_valid <= pin;
        pinned_result <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // hold the sender until every result word is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (key_result_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        result_t want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_INVERT_LEVEL:   inv_level = cfg_data[0];
                    CFG_DEBOUNCE_TICKS: debounce_cfg = cfg_data[DEBOUNCE_W-1:0];
                    CFG_REPEAT_PERIOD:  period_cfg = cfg_data[DELAY_W-1:0];
                    CFG_REPEAT_DELAY:   delay_cfg = cfg_data[DELAY_W-1:0];
                    CFG_LONG_PRESS:     long_cfg = cfg_data[DELAY_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (key_result_q.size() == 0) begin
                    $display("%0t: result word with nothing expected", $time);
                    errors++;
                end
                else begin
                    want = key_result_q.pop_front();
                    check_bit("press_event", want.press_event, press_event);
                    check_bit("repeat_flag", want.repeat_flag, repeat_flag);
                    check_bit("release_event", want.release_event, release_event);
                    check_bit("long_press_event", want.long_press_event, long_press_event);
                    check_bit("key_pressed", want.key_pressed, key_pressed);
                end
            end
            if (in_valid && !in_stall) begin
                want = next_key_result(raw_level);
                key_result_q.insert(key_result_q.size(), pinned_valid ? pinned_result : want);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        int unsigned dbv;
        int unsigned dbx;
        int unsigned run;
        int unsigned sent;
        int unsigned mode;
        logic        lvl;

        plan = '{
            row_tick_pin(1'b0, R_IDLE),
            row_tick_pin(1'b1, R_IDLE),
            row_tick_pin(1'b0, R_IDLE),
            row_write(CFG_DEBOUNCE_TICKS, 24'd0),
            row_tick_pin(1'b1, R_PRESS),
            row_tick_pin(1'b1, R_HELD),
            row_tick_pin(1'b0, R_RELEASE),
            row_write(CFG_REPEAT_PERIOD, 24'd1),
            row_write(CFG_LONG_PRESS, 24'd1),
            row_tick_pin(1'b1, R_PRESS),
            row_tick_pin(1'b1, R_REP_LONG),
            row_tick_pin(1'b1, R_REPEAT),
            row_tick_pin(1'b0, R_RELEASE),
            row_write(CFG_REPEAT_PERIOD, 24'd0),
            row_write(CFG_LONG_PRESS, 24'd3),
            row_tick_pin(1'b1, R_PRESS),
            row_tick_pin(1'b0, R_RELEASE),
            row_tick(1'b0),
            row_tick(1'b0),
            row_write(CFG_DEBOUNCE_TICKS, 24'd2),
            row_write(CFG_REPEAT_PERIOD, 24'd3),
            row_write(CFG_REPEAT_DELAY, 24'd2),
            row_tick(1'b1),
            row_tick(1'b0),
            row_tick(1'b0),
            row_tick(1'b0),
            row_write(CFG_INVERT_LEVEL, 24'd1),
            row_tick(1'b0),
            row_tick(1'b0),
            row_tick(1'b0),
            row_tick(1'b0),
            row_tick(1'b0),
            row_tick(1'b0),
            row_write(CFG_DEBOUNCE_TICKS, 24'd65535),
            row_write(CFG_REPEAT_PERIOD, 24'hFFFFFF),
            row_write(CFG_REPEAT_DELAY, 24'hFFFFFF),
            row_write(CFG_LONG_PRESS, 24'hFFFFFF),
            row_write(CFG_INVERT_LEVEL, 24'd0),
            row_tick(1'b0),
            row_tick(1'b1)
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < $size(plan); i++) begin
            if (plan[i].is_write) begin
                drain();
                write_reg(plan[i].reg_idx, plan[i].data);
            end
            else begin
                send_tick(plan[i].level, plan[i].pinned, plan[i].want);
            end
        end

        for (int ph = 0; ph < 12; ph++) begin
            drain();
            mode = $urandom_range(9);
            if (mode < 2)
                dbv = 0;
            else if (mode < 8)
                dbv = $urandom_range(1, 6);
            else if (mode == 8)
                dbv = $urandom_range(7, 40);
            else
                dbv = $urandom_range(0, 65535);
            dbx = (dbv > 40) ? 40 : dbv;
            write_reg(CFG_INVERT_LEVEL, CFG_DATA_W'($urandom_range(1)));
            write_reg(CFG_DEBOUNCE_TICKS, CFG_DATA_W'(dbv));
            write_reg(CFG_REPEAT_PERIOD, pick_span(8));
            write_reg(CFG_REPEAT_DELAY, pick_span(12));
            write_reg(CFG_LONG_PRESS, pick_span(30));
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 71; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 71; end
                default: begin send_idle_pct = 35; stall_pct <= 35; end
            endcase

            // runs of one level: bounces shorter than the debounce, noise, and clean holds
            sent = 0;
            lvl = logic'($urandom_range(1));
            while (sent < 60) begin
                mode = $urandom_range(9);
                lvl = !lvl;
                if (mode < 2)
                    run = $urandom_range(1, (dbx > 0) ? dbx : 1);
                else if (mode == 2)
                    run = $urandom_range(1, 6);
                else
                    run = dbx + 1 + $urandom_range(0, 25);
                for (int k = 0; k < run && sent < 60; k++) begin
                    send_tick((mode == 2) ? logic'($urandom_range(1)) : lvl, 1'b0, R_IDLE);
                    sent++;
                end
            end
        end

        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
src/kdrl_pkg.sv
src/key_debounce_repeat_longpress.sv
src/kdrl_checker.sv
verif/tb_key_debounce_repeat_longpress.sv
